### hw/rtl/srwc_pkg.sv
// Shared types and constants for the sequence replay window check.
// Used by srwc_cfg, srwc_ctrl, srwc_dp and the top level.
`default_nettype none

package srwc_pkg;

  // register port and payload widths
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned ST_W   = 3;

  // per-word result codes
  typedef enum logic [ST_W-1:0] {
    ST_COMPLETE = 3'd0,
    ST_GAP      = 3'd1,
    ST_OLD      = 3'd2,
    ST_UNSEQ    = 3'd3,
    ST_DUP      = 3'd4,
    ST_FAIL     = 3'd5
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_UPD
  } fsm_state_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic             replay_en;
    logic             seq_en;
    logic             wide;
    logic [SEQ_W-1:0] first_seq;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } dp_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/srwc_cfg.sv
// Register file for the sequence replay window check (APB-style port).
// Depends on srwc_pkg; raises a window reinit pulse after every write.
`default_nettype none

module srwc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srwc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [srwc_pkg::DATA_W-1:0] pwdata,
  output logic      [srwc_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output srwc_pkg::cfg_t                   cfg_o,
  output logic                             init_o
);
  import srwc_pkg::*;

  // register indexes
  localparam logic [1:0] REG_REPLAY = 2'd0;
  localparam logic [1:0] REG_SEQ    = 2'd1;
  localparam logic [1:0] REG_WIDE   = 2'd2;
  localparam logic [1:0] REG_FIRST  = 2'd3;

  cfg_t       cfg_q, cfg_d;
  logic       init_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_REPLAY: cfg_d.replay_en = pwdata[0];
        REG_SEQ:    cfg_d.seq_en    = pwdata[0];
        REG_WIDE:   cfg_d.wide      = pwdata[0];
        REG_FIRST:  cfg_d.first_seq = pwdata;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_REPLAY: prdata = {{(DATA_W-1){1'b0}}, cfg_q.replay_en};
      REG_SEQ:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.seq_en};
      REG_WIDE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.wide};
      REG_FIRST:  prdata = cfg_q.first_seq;
      default:    prdata = '0;
    endcase
  end

  // registers; reinit is registered, so it comes the cycle after the write and sees the new width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      init_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      init_q <= wr_en;
    end
  end

  assign cfg_o  = cfg_q;
  assign init_o = init_q;

endmodule

`default_nettype wire

### hw/rtl/srwc_ctrl.sv
// Controller for the sequence replay window check: load, compare, update.
// Depends on srwc_pkg; drives the datapath through a command struct.
`default_nettype none

module srwc_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        out_stall_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output srwc_pkg::dp_cmd_t cmd_o
);
  import srwc_pkg::*;

  fsm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_done;
  logic       in_stall;
  logic       accept;

  // outputs and commands
  always_comb begin
    can_done = !out_valid_q || !out_stall_i;
    case (state_q)
      FSM_IDLE: in_stall = 1'b0;
      FSM_CMP:  in_stall = 1'b1;
      FSM_UPD:  in_stall = !can_done;
      default:  in_stall = 1'b1;
    endcase
    accept     = in_valid_i && !in_stall;
    cmd_o.load = accept;
    cmd_o.cmp  = (state_q == FSM_CMP);
    cmd_o.upd  = (state_q == FSM_UPD) && can_done;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_CMP;
      end
      FSM_CMP: state_d = FSM_UPD;
      FSM_UPD: begin
        if (can_done) state_d = accept ? FSM_CMP : FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // output word valid: set by an update, held while stalled
  assign out_valid_d = cmd_o.upd || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/srwc_dp.sv
// Datapath for the sequence replay window check: sorted window lanes,
// per-lane compare flags, insert/shift logic and the status register.
// Depends on srwc_pkg.
`default_nettype none

module srwc_dp #(
  parameter int unsigned WINDOW_DEPTH = 20
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire srwc_pkg::cfg_t             cfg_i,
  input  wire logic                       init_i,
  input  wire srwc_pkg::dp_cmd_t          cmd_i,
  input  wire logic [srwc_pkg::SEQ_W-1:0] seq_num_i,
  output logic      [srwc_pkg::ST_W-1:0]  status_o
);
  import srwc_pkg::*;

  localparam int unsigned D  = WINDOW_DEPTH;
  localparam int unsigned PW = $clog2(D);
  localparam int unsigned FW = $clog2(D + 1);

  logic [SEQ_W-1:0] mask;
  logic [SEQ_W-1:0] r_q;
  logic [SEQ_W-1:0] last_q, last_d;
  logic [SEQ_W-1:0] win_q [D];
  logic [SEQ_W-1:0] win_d [D];
  logic [FW-1:0]    fill_q, fill_d;
  logic [ST_W-1:0]  st_q;

  // compare flags
  logic [D-1:0] eq_q, gt_q;
  logic         exp_eq_q, exp_gt_q, old_q, last_eq_q, sent_q;

  // update decode
  logic [D-1:0] lane_v, lt, hit, first_hit;
  logic [PW-1:0] hit_pos, ins_pos;
  logic          ins, append, full, replay_only;
  status_e       st_d;

  assign mask = cfg_i.wide ? {SEQ_W{1'b1}} : {{(SEQ_W/2){1'b0}}, {(SEQ_W/2){1'b1}}};

  // relative number on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= (seq_num_i - cfg_i.first_seq) & mask;
  end

  // compare cycle: every lane against r in parallel
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      for (int k = 0; k < D; k++) begin
        eq_q[k] <= (r_q == win_q[k]);
        gt_q[k] <= (r_q > win_q[k]);
      end
      exp_eq_q  <= (r_q == ((last_q + 64'd1) & mask));
      exp_gt_q  <= (r_q > ((last_q + 64'd1) & mask));
      old_q     <= (r_q < win_q[0]) && (cfg_i.wide ? r_q[SEQ_W-1] : r_q[SEQ_W/2-1]);
      last_eq_q <= (r_q == last_q);
      sent_q    <= (win_q[0] == mask);
    end
  end

  // lane hits: equal to lane k, or strictly between lane k and lane k+1
  always_comb begin
    for (int k = 0; k < D; k++) begin
      lane_v[k] = FW'(k) < fill_q;
      lt[k]     = !eq_q[k] && !gt_q[k];
    end
    for (int k = 0; k < D - 1; k++) begin
      hit[k] = lane_v[k+1] && (eq_q[k] || (gt_q[k] && lt[k+1]));
    end
    hit[D-1]  = 1'b0;
    first_hit = hit & (~hit + D'(1));
    hit_pos   = '0;
    for (int k = 0; k < D; k++) begin
      if (first_hit[k]) hit_pos = hit_pos | PW'(k);
    end
  end

  // rule priority and status
  always_comb begin
    replay_only = cfg_i.replay_en && !cfg_i.seq_en;
    ins         = 1'b0;
    append      = 1'b0;
    ins_pos     = PW'(fill_q - FW'(1));
    st_d        = ST_FAIL;
    if (!cfg_i.replay_en && !cfg_i.seq_en) begin
      st_d = ST_COMPLETE;
    end else if (exp_eq_q) begin
      ins    = 1'b1;
      append = 1'b1;
      st_d   = ST_COMPLETE;
    end else if (exp_gt_q) begin
      ins    = 1'b1;
      append = 1'b1;
      st_d   = replay_only ? ST_COMPLETE : ST_GAP;
    end else if (old_q) begin
      st_d = replay_only ? ST_OLD : ST_UNSEQ;
    end else if (last_eq_q) begin
      st_d = ST_DUP;
    end else if (|hit) begin
      if (|(first_hit & eq_q)) begin
        st_d = ST_DUP;
      end else begin
        ins     = 1'b1;
        ins_pos = hit_pos;
        st_d    = replay_only ? ST_COMPLETE : ST_UNSEQ;
      end
    end else if (sent_q && lane_v[1] && lt[1]) begin
      // first token out of order: goes right after the sentinel
      ins     = 1'b1;
      ins_pos = '0;
      st_d    = replay_only ? ST_COMPLETE : ST_UNSEQ;
    end
  end

  assign full = (fill_q == FW'(D));

  // insert after ins_pos; a full window drops its oldest lane
  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_lane
      logic [SEQ_W-1:0] from_up, from_dn;
      if (g < D - 1) begin : g_up
        assign from_up = win_q[g+1];
      end else begin : g_up_end
        assign from_up = win_q[g];
      end
      if (g > 0) begin : g_dn
        assign from_dn = win_q[g-1];
      end else begin : g_dn_end
        assign from_dn = win_q[g];
      end
      always_comb begin
        if (full) begin
          if (PW'(g) < ins_pos)       win_d[g] = from_up;
          else if (PW'(g) == ins_pos) win_d[g] = r_q;
          else                        win_d[g] = win_q[g];
        end else begin
          if (PW'(g) <= ins_pos)                          win_d[g] = win_q[g];
          else if ((PW+1)'(g) == ({1'b0, ins_pos} + 1'b1)) win_d[g] = r_q;
          else                                            win_d[g] = from_dn;
        end
      end
      if (g == 0) begin : g_head
        // oldest lane holds the sentinel after reset and reinit
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            win_q[g] <= {{(SEQ_W/2){1'b0}}, {(SEQ_W/2){1'b1}}};
          end else if (init_i) begin
            win_q[g] <= mask;
          end else if (cmd_i.upd && ins) begin
            win_q[g] <= win_d[g];
          end
        end
      end else begin : g_body
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            win_q[g] <= '0;
          end else if (cmd_i.upd && ins && !init_i) begin
            win_q[g] <= win_d[g];
          end
        end
      end
    end
  endgenerate

  // fill count and newest entry
  always_comb begin
    fill_d = fill_q;
    last_d = last_q;
    if (init_i) begin
      fill_d = FW'(1);
      last_d = mask;
    end else if (cmd_i.upd && ins) begin
      if (!full) fill_d = fill_q + FW'(1);
      if (append) last_d = r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FW'(1);
      last_q <= {{(SEQ_W/2){1'b0}}, {(SEQ_W/2){1'b1}}};
    end else begin
      fill_q <= fill_d;
      last_q <= last_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) st_q <= st_d;
  end

  assign status_o = st_q;

endmodule

`default_nettype wire

### hw/rtl/sequence_replay_window_check.sv
// Top level of the sequence replay window check.
// Depends on srwc_pkg, srwc_cfg, srwc_ctrl and srwc_dp.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------
//   in       | in_valid_i / in_stall_o | seq_num_i   (64 bit)
//   out      | out_valid_o/ out_stall_i| status_o    (3 bit)
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata
//
// Each word is compared against every window lane in parallel into registered flags
// in the compare state; the update state resolves the rule and shifts the lanes.
// A new word can be taken in the update state, while the previous word finishes.
// Reset leaves one sentinel entry (all ones, 32-bit width); any register write
// reinitializes the window the cycle after. A stalled output holds the update.
`default_nettype none

module sequence_replay_window_check #(
  parameter int unsigned WINDOW_DEPTH = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [srwc_pkg::SEQ_W-1:0]  seq_num_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [srwc_pkg::ST_W-1:0]   status_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srwc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [srwc_pkg::DATA_W-1:0] pwdata,
  output logic      [srwc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import srwc_pkg::*;

  cfg_t    cfg;
  logic    init;
  dp_cmd_t cmd;

  srwc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .init_o  (init)
  );

  srwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  srwc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .init_i    (init),
    .cmd_i     (cmd),
    .seq_num_i (seq_num_i),
    .status_o  (status_o)
  );

endmodule

`default_nettype wire

### tb/sv/sequence_replay_window_check_tb.sv
// Self-checking bench for sequence_replay_window_check: a directed table, then random phases.
// Drives words through the valid/stall channels and registers through the APB port.
// Checks each status against the directed table or a window predictor. Depends on srwc_pkg and the top level RTL.
module sequence_replay_window_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srwc_pkg::*;

  localparam int unsigned WINDOW_DEPTH    = 20;
  localparam int unsigned REG_REPLAY      = 0;
  localparam int unsigned REG_SEQUENCE    = 1;
  localparam int unsigned REG_WIDE        = 2;
  localparam int unsigned REG_FIRST       = 3;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned WORDS_PER_PHASE = 164;
  localparam int unsigned PRINT_CAP       = 40;
  localparam logic [63:0] MASK32          = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_RAMP} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int unsigned reg_idx;
    logic [63:0] value;
    int unsigned count;
    bit          fixed;
    status_e     want;
  } plan_row_t;

  // dut ports, inputs driven from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [SEQ_W-1:0]  seq_num_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state: register mirror and sorted circular window
  bit          cfg_replay;
  bit          cfg_seq;
  bit          cfg_wide;
  logic [63:0] cfg_first;
  logic [63:0] win_val [WINDOW_DEPTH];
  int unsigned win_head;
  int unsigned win_count;

  status_e     status_due [$];
  plan_row_t   plan [$];
  bit          no_idle;
  int unsigned mismatch_cnt;
  int unsigned words_sent;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned status_seen [6];

  sequence_replay_window_check #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .seq_num_i  (seq_num_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned win_slot(int unsigned k);
    return (win_head + k) % WINDOW_DEPTH;
  endfunction

  // back to a single all-ones sentinel at the current width
  function automatic void window_clear();
    foreach (win_val[i]) win_val[i] = '0;
    win_head   = 0;
    win_count  = 1;
    win_val[0] = cfg_wide ? '1 : MASK32;
  endfunction

  // place v right after logical position pos, dropping the oldest when full
  function automatic void window_insert(int unsigned pos, logic [63:0] v);
    for (int unsigned k = win_count; k > pos + 1; k--)
      win_val[win_slot(k)] = win_val[win_slot(k - 1)];
    win_val[win_slot(pos + 1)] = v;
    if (win_count >= WINDOW_DEPTH) win_head = (win_head + 1) % WINDOW_DEPTH;
    else win_count++;
  endfunction

  // status of one sequence number, updating the window as the block would
  function automatic status_e replay_verdict(logic [63:0] seq);
    logic [63:0] m, r, newest, nxt, oldest, top;
    bit          replay_only;
    int unsigned lastpos;
    status_e     in_order;
    m           = cfg_wide ? '1 : MASK32;
    replay_only = cfg_replay && !cfg_seq;
    in_order    = replay_only ? ST_COMPLETE : ST_UNSEQ;
    if (!cfg_replay && !cfg_seq) return ST_COMPLETE;
    r       = (seq - cfg_first) & m;
    lastpos = win_count - 1;
    newest  = win_val[win_slot(lastpos)];
    nxt     = (newest + 64'd1) & m;
    // expected next or anything later is appended
    if (r == nxt) begin
      window_insert(lastpos, r);
      return ST_COMPLETE;
    end
    if (r > nxt) begin
      window_insert(lastpos, r);
      return replay_only ? ST_COMPLETE : ST_GAP;
    end
    // behind the window with the top bit set
    oldest = win_val[win_slot(0)];
    top    = 64'd1 + (m >> 1);
    if (r < oldest && (r & top) != 0) return replay_only ? ST_OLD : ST_UNSEQ;
    if (r == newest) return ST_DUP;
    // walk the window for a repeat or a hole to fill
    for (int unsigned k = 0; k < lastpos; k++) begin
      if (r == win_val[win_slot(k)]) return ST_DUP;
      if (r > win_val[win_slot(k)] && r < win_val[win_slot(k + 1)]) begin
        window_insert(k, r);
        return in_order;
      end
    end
    // first token arriving out of order, sentinel still oldest
    if (oldest == m && win_val[win_slot(1)] > r) begin
      window_insert(0, r);
      return in_order;
    end
    return ST_FAIL;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(logic [63:0] seq, bit fixed, status_e want);
    status_e verdict;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    seq_num_i  = seq;
    do @(posedge clk_i); while (in_stall_o);
    verdict = replay_verdict(seq);
    status_due.push_back(fixed ? want : verdict);
    words_sent++;
  endtask

  // drop valid and hold off until every status is back and the block settles
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write, then read back the same register
  task automatic reg_write(int unsigned idx, logic [63:0] val);
    logic [63:0] got, want;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx * 8);
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_REPLAY:   cfg_replay = val[0];
      REG_SEQUENCE: cfg_seq    = val[0];
      REG_WIDE:     cfg_wide   = val[0];
      default:      cfg_first  = val;
    endcase
    window_clear();
    cfg_writes++;
    // back-to-back read of the same address
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got  = prdata;
    want = (idx == REG_FIRST) ? val : {63'd0, val[0]};
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= PRINT_CAP)
        $display("%0t: register %0d readback, expected %h got %h", $time, idx, want, got);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic void add_cfg(int unsigned idx, logic [63:0] val);
    plan.push_back('{ROW_CFG, idx, val, 0, 1'b0, ST_COMPLETE});
  endfunction

  function automatic void add_word(logic [63:0] seq, bit fixed, status_e want);
    plan.push_back('{ROW_WORD, 0, seq, 1, fixed, want});
  endfunction

  // output side stalls at random except in the no-idle stretch
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 28);
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : check_status
    status_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
          $display("%0t: status word with none pending, expected nothing got %0d",
                   $time, status_o);
      end else begin
        want = status_due.pop_front();
        if (status_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= PRINT_CAP)
            $display("%0t: status mismatch, expected %0d (%s) got %0d",
                     $time, want, want.name(), status_o);
        end
        if (status_o < 6) status_seen[status_o]++;
      end
    end
  end

  // watchdog on cycles with no word, no status and no register access
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d statuses still pending",
               $time, STALL_LIMIT, status_due.size());
      $display("** sequence_replay_window_check: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    logic [63:0] first, m, newest, rel, seq, noise;
    bit          rep, sq, wd;
    int unsigned pick;

    cfg_replay = 1'b0;
    cfg_seq    = 1'b0;
    cfg_wide   = 1'b0;
    cfg_first  = '0;
    window_clear();

    // both checks off out of reset: everything passes
    add_word(64'd0, 1'b1, ST_COMPLETE);
    add_word('1, 1'b1, ST_COMPLETE);
    // replay-only, 32 bit, first number zero
    add_cfg(REG_REPLAY, 64'd1);
    add_word(64'd0, 1'b1, ST_COMPLETE);
    add_word(64'd0, 1'b1, ST_DUP);
    add_word(64'd5, 1'b1, ST_COMPLETE);
    add_word(64'd3, 1'b1, ST_COMPLETE);
    add_word(64'd3, 1'b1, ST_DUP);
    add_word(64'h0000_0000_FFFF_FFF0, 1'b1, ST_COMPLETE);
    add_word(64'h0000_0000_8000_0000, 1'b1, ST_OLD);
    // sequence mode too; upper half must be ignored
    add_cfg(REG_SEQUENCE, 64'd1);
    add_word(64'hABCD_0123_FFFF_FFF0, 1'b1, ST_GAP);
    add_word(64'h0000_0000_8000_0000, 1'b1, ST_UNSEQ);
    add_word(64'h0000_0000_0000_0010, 1'b1, ST_UNSEQ);
    add_word(64'hFFFF_0000_0000_0010, 1'b1, ST_DUP);
    add_word(64'h5555_5555_FFFF_FFF1, 1'b1, ST_COMPLETE);
    // 64 bit with first number near the top, so relative values wrap
    add_cfg(REG_FIRST, 64'hFFFF_FFFF_FFFF_FFF0);
    add_cfg(REG_WIDE, 64'd1);
    add_word(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, ST_COMPLETE);
    add_word(64'h7FFF_FFFF_FFFF_FFF0, 1'b1, ST_GAP);
    // sequence only: fill the window past the sentinel, then fall behind it
    add_cfg(REG_REPLAY, 64'd0);
    plan.push_back('{ROW_RAMP, 0, 64'hFFFF_FFFF_FFFF_FFF0, WINDOW_DEPTH + 1, 1'b0, ST_COMPLETE});
    add_word(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, ST_FAIL);
    add_word(64'hFFFF_FFFF_FFFF_FFFA, 1'b0, ST_COMPLETE);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          wait_idle();
          reg_write(plan[i].reg_idx, plan[i].value);
        end
        ROW_WORD: send_word(plan[i].value, plan[i].fixed, plan[i].want);
        default: begin
          for (int unsigned k = 0; k < plan[i].count; k++)
            send_word(plan[i].value + k, 1'b0, ST_COMPLETE);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rep = 1'b1; sq = 1'b0; wd = 1'b0; first = '0; end
        1: begin rep = 1'b0; sq = 1'b1; wd = 1'b1; first = '1; end
        2: begin rep = 1'b1; sq = 1'b1; wd = 1'b0; first = MASK32; end
        3: begin rep = 1'b0; sq = 1'b0; wd = 1'b1; first = {$urandom, $urandom}; end
        default: begin
          rep   = $urandom_range(0, 1);
          sq    = $urandom_range(0, 1);
          wd    = $urandom_range(0, 1);
          first = {$urandom, $urandom};
          if (!rep && !sq) rep = 1'b1;
        end
      endcase
      wait_idle();
      no_idle = (p == 5);
      noise   = {$urandom, $urandom};
      reg_write(REG_FIRST, first);
      reg_write(REG_WIDE, {noise[63:1], wd});
      reg_write(REG_REPLAY, {noise[62:0], rep});
      reg_write(REG_SEQUENCE, {~noise[63:1], sq});
      m = wd ? '1 : MASK32;

      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        // sender holds off mid-phase until every status is back
        if (n == WORDS_PER_PHASE / 2) wait_idle();
        newest = win_val[win_slot(win_count - 1)];
        pick   = $urandom_range(0, 99);
        if (pick < 55)      rel = newest + 64'd1;
        else if (pick < 65) rel = newest + 64'd2 + $urandom_range(0, 6);
        else if (pick < 80) rel = newest - $urandom_range(0, WINDOW_DEPTH + 4);
        else if (pick < 85) rel = newest - $urandom_range(WINDOW_DEPTH + 5, 300);
        else if (pick < 90) rel = newest ^ (64'd1 + (m >> 1));
        else if (pick < 93) rel = m - $urandom_range(0, 2);
        else                rel = {$urandom, $urandom};
        seq = rel + first;
        if (!wd) seq[63:32] = $urandom;
        send_word(seq, 1'b0, ST_COMPLETE);
      end
    end

    no_idle = 1'b0;
    wait_idle();

    $display("covered %0d words under %0d register writes, %0d random phases",
             words_sent, cfg_writes, PHASES);
    $display("statuses: complete %0d gap %0d old %0d unseq %0d dup %0d fail %0d",
             status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5]);
    if (mismatch_cnt == 0) begin
      $display("** sequence_replay_window_check: PASSED **");
    end else begin
      $display("** sequence_replay_window_check: FAILED **");
    end
    $finish;
  end

endmodule

### sequence_replay_window_check.f
hw/rtl/srwc_pkg.sv
hw/rtl/srwc_cfg.sv
hw/rtl/srwc_ctrl.sv
hw/rtl/srwc_dp.sv
hw/rtl/sequence_replay_window_check.sv
tb/sv/sequence_replay_window_check_tb.sv
